### design/scrollback_text_buffer_assert.svh
// ----------------------------------------------------------------------------
// Scrollback text buffer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SCROLLBACK_TEXT_BUFFER_ASSERT_SVH
`define SCROLLBACK_TEXT_BUFFER_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define STB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define STB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/stb_pkg.sv
// ----------------------------------------------------------------------------
// Scrollback text buffer package
// Field widths, codes and channel payload types.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int DIR_W     = 2;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 5;
    localparam int FILL_W    = 10;
    localparam int SCROLL_W  = 5;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    // wide enough for any screen geometry value
    localparam int GEOM_W    = 7;

    localparam int KEEP_LENGTH_RESET = 500;
    localparam int DROP_STEP_RESET   = 20;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE   = 2'd0,
        FUNC_JOYSTICK  = 2'd1,
        FUNC_CELL_READ = 2'd2
    } func_e;

    typedef enum logic [DIR_W-1:0] {
        DIR_IDLE  = 2'd0,
        DIR_NORTH = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_OTHER = 2'd3
    } dir_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEEP_LENGTH = 1'b0,
        CFG_DROP_STEP   = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] rx_byte;
        logic [DIR_W-1:0]  direction;
        logic [ROW_W-1:0]  screen_row;
        logic [COL_W-1:0]  screen_col;
    } stb_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]   cell_char;
        logic                row_shown;
        logic [FILL_W-1:0]   fill_length;
        logic [SCROLL_W-1:0] scroll_lines;
    } stb_rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_W-1:0]     wdata;
    } stb_cfg_t;

endpackage

### design/stb_chan_if.sv
// ----------------------------------------------------------------------------
// Scrollback text buffer channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface stb_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### design/stb_mem.sv
// ----------------------------------------------------------------------------
// Scrollback text store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module stb_mem #(
    parameter int DEPTH = 520,
    parameter int AW    = 10
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [stb_pkg::CHAR_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [stb_pkg::CHAR_W-1:0] rd_data
);

    logic [stb_pkg::CHAR_W-1:0] mem_array [DEPTH];
    logic [stb_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/stb_cfg.sv
// ----------------------------------------------------------------------------
// Scrollback text buffer configuration
// Holds keep length (saturated) and drop step (reduced modulo the store size).
// ----------------------------------------------------------------------------
module stb_cfg #(
    parameter int BUFFER_BYTES = 520,
    parameter int LW           = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr,
    input  logic [stb_pkg::CFG_IDX_W-1:0] wr_addr,
    input  logic [stb_pkg::CFG_W-1:0]     wr_data,
    output logic [LW-1:0]                 keep_len,
    output logic [LW-1:0]                 drop_mod,
    output logic                          busy
);

    localparam int DW = (stb_pkg::CFG_W > LW) ? stb_pkg::CFG_W : LW;
    localparam int KEEP_RST = (stb_pkg::KEEP_LENGTH_RESET > BUFFER_BYTES - 1)
                            ? BUFFER_BYTES - 1 : stb_pkg::KEEP_LENGTH_RESET;
    localparam int DROP_RST = stb_pkg::DROP_STEP_RESET % BUFFER_BYTES;

    logic [LW-1:0] keep_reg;
    logic [LW-1:0] keep_next;
    logic [DW-1:0] drop_reg;
    logic [DW-1:0] drop_next;
    logic          busy_reg;
    logic          busy_next;
    logic [DW:0]   wdata_ext;
    logic          wdata_big;
    logic          drop_big;

    assign wdata_ext = (DW+1)'(wr_data);
    assign wdata_big = wdata_ext > (DW+1)'(BUFFER_BYTES - 1);
    assign drop_big  = {1'b0, drop_reg} >= (DW+1)'(BUFFER_BYTES);

    always_comb
    begin
        keep_next = keep_reg;
        drop_next = drop_reg;
        busy_next = busy_reg;
        // reduce the drop step one store length a cycle
        if (busy_reg)
        begin
            if (drop_big)
            begin
                drop_next = DW'({1'b0, drop_reg} - (DW+1)'(BUFFER_BYTES));
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
        if (wr)
        begin
            case (stb_pkg::cfg_reg_e'(wr_addr))
                stb_pkg::CFG_KEEP_LENGTH:
                begin
                    keep_next = wdata_big ? LW'(BUFFER_BYTES - 1) : LW'(wdata_ext);
                end
                stb_pkg::CFG_DROP_STEP:
                begin
                    drop_next = DW'(wdata_ext);
                    busy_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= LW'(KEEP_RST);
            drop_reg <= DW'(DROP_RST);
            busy_reg <= 1'b0;
        end
        else
        begin
            keep_reg <= keep_next;
            drop_reg <= drop_next;
            busy_reg <= busy_next;
        end
    end

    assign keep_len = keep_reg;
    assign drop_mod = LW'(drop_reg);
    assign busy     = busy_reg;

endmodule

### design/scrollback_text_buffer.sv
// ----------------------------------------------------------------------------
// Scrollback text buffer
// Circular character store behind a scrolling 20 x 16 text display.
// ----------------------------------------------------------------------------
//
//  channel  dir   payload                                         transfer
//  -------  ----  ----------------------------------------------  ---------------
//  cmd      in    func, rx_byte, direction, screen_row, screen_col  valid & ready
//  rsp      out   cell_char, row_shown, fill_length, scroll_lines   valid & ready
//  cfg      in    addr (0 keep_length, 1 drop_step), wdata          valid & ready
//
//  One command a cycle sustained while rsp is ready and no drop_step is being
//  reduced; each command gives one response, registered through stage p1 (read
//  address), stage p2 (read data) and the response register in turn.
//  A drop_step write holds cmd ready low while the step is reduced modulo the
//  store size. No clearing pass after reset.
//  A stalled rsp back-pressures the stages in turn.
// ----------------------------------------------------------------------------
module scrollback_text_buffer #(
    parameter int BUFFER_BYTES = 520,
    parameter int LINE_CHARS   = 20,
    parameter int SCREEN_ROWS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    stb_chan_if.sink   cmd,
    stb_chan_if.source rsp,
    stb_chan_if.sink   cfg
);

    // Index and length width: holds every value up to BUFFER_BYTES - 1
    localparam int LW    = $clog2(BUFFER_BYTES);
    // Line number width: last line plus a screen row
    localparam int LNW   = LW + 1;
    localparam int IDXW  = LNW + stb_pkg::GEOM_W;
    // Reciprocal for (length-1)/LINE_CHARS; exact for all LW-bit dividends
    localparam int RECIP_SHIFT = LW + $clog2(LINE_CHARS);
    localparam int RECIP_MULT  = (2**RECIP_SHIFT + LINE_CHARS - 1) / LINE_CHARS;
    localparam int MW          = LW + 2;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic          cfg_fire;
    logic [LW-1:0] keep_len;
    logic [LW-1:0] drop_mod;
    logic          cfg_busy;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    stb_cfg #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .LW          (LW)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cfg_fire),
        .wr_addr (cfg.data.addr),
        .wr_data (cfg.data.wdata),
        .keep_len(keep_len),
        .drop_mod(drop_mod),
        .busy    (cfg_busy)
    );

    // ------------------------------------------------------------------
    // Buffer state
    // ------------------------------------------------------------------
    logic [LW-1:0] start_reg,    start_next;
    logic [LW-1:0] len_reg,      len_next;
    logic [LW-1:0] scroll_reg,   scroll_next;
    logic          armed_reg,    armed_next;
    logic [LW-1:0] lastline_reg, lastline_next;

    // ------------------------------------------------------------------
    // Stage control: p1 computes the read address, p2 waits on read data
    // ------------------------------------------------------------------
    logic p1_valid_reg, p1_valid_next;
    logic p2_valid_reg, p2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, p2_free, p1_free, p2_adv, p1_adv, cmd_fire;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign p2_adv    = p2_valid_reg && out_free;
    assign p2_free   = !p2_valid_reg || out_free;
    assign p1_adv    = p1_valid_reg && p2_free;
    assign p1_free   = !p1_valid_reg || p2_free;
    assign cmd.ready = p1_free && !cfg_busy;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // ------------------------------------------------------------------
    // Accept stage: state update and cell row decode
    // ------------------------------------------------------------------
    logic [LW:0]         wr_sum;
    logic [LW-1:0]       wr_addr;
    logic                wr_en;
    logic                len_full;
    logic [LW:0]         adv_sum;
    logic [LW-1:0]       start_adv;
    logic [LW-1:0]       len_rx;
    logic [LW-1:0]       ll_dividend;
    logic [LW+MW-1:0]    ll_prod;
    logic [LW-1:0]       ll_calc;
    logic [LW-1:0]       top_limit;
    logic [LW:0]         scroll_cand;
    logic [LW-1:0]       scroll_clamp;
    logic                move_up, move_down;
    logic [LW-1:0]       view_top;
    logic [LNW-1:0]      line_a;
    logic                row_ok, col_ok;
    logic                shown_a, chk_a;

    assign wr_sum  = {1'b0, start_reg} + {1'b0, len_reg};
    assign wr_addr = (wr_sum >= (LW+1)'(BUFFER_BYTES))
                   ? LW'(wr_sum - (LW+1)'(BUFFER_BYTES)) : LW'(wr_sum);
    assign len_full = (len_reg == LW'(BUFFER_BYTES - 1));

    // Advance the start by the drop step, wrapping round the store
    assign adv_sum   = {1'b0, start_reg} + {1'b0, drop_mod};
    assign start_adv = (adv_sum >= (LW+1)'(BUFFER_BYTES))
                     ? LW'(adv_sum - (LW+1)'(BUFFER_BYTES)) : LW'(adv_sum);
    assign len_rx    = len_full ? keep_len : len_reg + LW'(1);

    // Last line of the new length; zero for an empty store
    assign ll_dividend = (len_rx == '0) ? '0 : len_rx - LW'(1);
    assign ll_prod     = ({{MW{1'b0}}, ll_dividend}) * ({{LW{1'b0}}, MW'(RECIP_MULT)});
    assign ll_calc     = LW'(ll_prod >> RECIP_SHIFT);

    // Highest useful scroll: last line less a screen, floored at zero
    assign top_limit = (lastline_reg > LW'(SCREEN_ROWS - 1))
                     ? lastline_reg - LW'(SCREEN_ROWS - 1) : '0;

    // Move only on the first non-idle sample after an idle one
    assign move_up   = (stb_pkg::dir_e'(cmd.data.direction) == stb_pkg::DIR_NORTH)
                     && armed_reg;
    assign move_down = (stb_pkg::dir_e'(cmd.data.direction) == stb_pkg::DIR_SOUTH)
                     && armed_reg;
    assign scroll_cand = move_up ? {1'b0, scroll_reg} + (LW+1)'(1)
                       : (move_down && scroll_reg != '0) ? {1'b0, scroll_reg} - (LW+1)'(1)
                       : {1'b0, scroll_reg};
    assign scroll_clamp = (scroll_cand > {1'b0, top_limit}) ? top_limit : LW'(scroll_cand);

    // Top line of the view; saturate where a shrunken store leaves scroll high
    assign view_top = (top_limit > scroll_reg) ? top_limit - scroll_reg : '0;
    assign line_a   = {1'b0, view_top} + LNW'(cmd.data.screen_row);
    assign row_ok   = stb_pkg::GEOM_W'(cmd.data.screen_row)
                    < stb_pkg::GEOM_W'(SCREEN_ROWS);
    assign col_ok   = stb_pkg::GEOM_W'(cmd.data.screen_col)
                    < stb_pkg::GEOM_W'(LINE_CHARS);

    always_comb
    begin
        start_next    = start_reg;
        len_next      = len_reg;
        scroll_next   = scroll_reg;
        armed_next    = armed_reg;
        lastline_next = lastline_reg;
        wr_en         = 1'b0;
        shown_a       = 1'b0;
        chk_a         = 1'b0;
        if (cmd_fire)
        begin
            case (stb_pkg::func_e'(cmd.data.func))
                stb_pkg::FUNC_RX_BYTE:
                begin
                    wr_en         = 1'b1;
                    len_next      = len_rx;
                    lastline_next = ll_calc;
                    // drop the oldest bytes once the store is full
                    if (len_full)
                    begin
                        start_next = start_adv;
                    end
                end
                stb_pkg::FUNC_JOYSTICK:
                begin
                    scroll_next = scroll_clamp;
                    armed_next  = (stb_pkg::dir_e'(cmd.data.direction) == stb_pkg::DIR_IDLE);
                end
                stb_pkg::FUNC_CELL_READ:
                begin
                    shown_a = row_ok && (line_a <= {1'b0, lastline_reg});
                    chk_a   = row_ok && col_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage p1 registers: snapshot of the state the read must see
    // ------------------------------------------------------------------
    logic [LNW-1:0]            p1_line_reg;
    logic [stb_pkg::COL_W-1:0] p1_col_reg;
    logic                      p1_chk_reg;
    logic                      p1_shown_reg;
    logic [LW-1:0]             p1_start_reg;
    logic [LW-1:0]             p1_fill_reg;
    logic [LW-1:0]             p1_scroll_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            p1_line_reg   <= line_a;
            p1_col_reg    <= cmd.data.screen_col;
            p1_chk_reg    <= chk_a;
            p1_shown_reg  <= shown_a;
            p1_start_reg  <= start_reg;
            p1_fill_reg   <= len_next;
            p1_scroll_reg <= scroll_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage p1 logic: cell index, range check, store address
    // ------------------------------------------------------------------
    logic [IDXW-1:0] idx;
    logic            idx_ok;
    logic [LW:0]     rd_sum;
    logic [LW-1:0]   rd_addr;
    logic            rd_en;

    assign idx     = IDXW'(p1_line_reg) * IDXW'(LINE_CHARS) + IDXW'(p1_col_reg);
    assign idx_ok  = p1_chk_reg && (idx < IDXW'(p1_fill_reg));
    assign rd_sum  = {1'b0, p1_start_reg} + {1'b0, idx[LW-1:0]};
    assign rd_addr = (rd_sum >= (LW+1)'(BUFFER_BYTES))
                   ? LW'(rd_sum - (LW+1)'(BUFFER_BYTES)) : LW'(rd_sum);
    // Read only cells inside the stored text
    assign rd_en   = p1_adv && idx_ok;

    logic [stb_pkg::CHAR_W-1:0] rd_data;

    stb_mem #(
        .DEPTH(BUFFER_BYTES),
        .AW   (LW)
    ) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(cmd.data.rx_byte),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // ------------------------------------------------------------------
    // Stage p2 registers: wait for the read data
    // ------------------------------------------------------------------
    logic          p2_ok_reg;
    logic          p2_shown_reg;
    logic [LW-1:0] p2_fill_reg;
    logic [LW-1:0] p2_scroll_reg;

    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            p2_ok_reg     <= idx_ok;
            p2_shown_reg  <= p1_shown_reg;
            p2_fill_reg   <= p1_fill_reg;
            p2_scroll_reg <= p1_scroll_reg;
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    logic [stb_pkg::CHAR_W-1:0]   out_char_reg;
    logic                         out_shown_reg;
    logic [stb_pkg::FILL_W-1:0]   out_fill_reg;
    logic [stb_pkg::SCROLL_W-1:0] out_scroll_reg;

    always_ff @(posedge clk)
    begin
        if (p2_adv)
        begin
            out_char_reg   <= p2_ok_reg ? rd_data : '0;
            out_shown_reg  <= p2_shown_reg;
            out_fill_reg   <= stb_pkg::FILL_W'(p2_fill_reg);
            out_scroll_reg <= stb_pkg::SCROLL_W'(p2_scroll_reg);
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.data.cell_char    = out_char_reg;
    assign rsp.data.row_shown    = out_shown_reg;
    assign rsp.data.fill_length  = out_fill_reg;
    assign rsp.data.scroll_lines = out_scroll_reg;

    // ------------------------------------------------------------------
    // Valid bits: advance on a free downstream slot, hold otherwise
    // ------------------------------------------------------------------
    always_comb
    begin
        p1_valid_next  = cmd_fire ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_reg);
        p2_valid_next  = p1_adv   ? 1'b1 : (p2_adv ? 1'b0 : p2_valid_reg);
        out_valid_next = p2_adv   ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            len_reg       <= '0;
            scroll_reg    <= '0;
            armed_reg     <= 1'b1;
            lastline_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            len_reg       <= len_next;
            scroll_reg    <= scroll_next;
            armed_reg     <= armed_next;
            lastline_reg  <= lastline_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/stb_checker.sv
// ----------------------------------------------------------------------------
// Scrollback text buffer port checker
// Watches the response channel of the top level.
// ----------------------------------------------------------------------------
`include "scrollback_text_buffer_assert.svh"

module stb_checker #(
    parameter int BUFFER_BYTES = 520,
    parameter int LINE_CHARS   = 20,
    parameter int SCREEN_ROWS  = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input stb_pkg::stb_rsp_t rsp_data
);

    // Last line of a full store and the highest scroll it allows
    localparam int MAX_LAST_LINE = (BUFFER_BYTES - 2) / LINE_CHARS;
    localparam int MAX_SCROLL    = (MAX_LAST_LINE > SCREEN_ROWS - 1)
                                 ? MAX_LAST_LINE - (SCREEN_ROWS - 1) : 0;

    logic fill_in_range;
    logic scroll_in_range;

    assign fill_in_range   = 32'(rsp_data.fill_length) <= BUFFER_BYTES - 1;
    assign scroll_in_range = 32'(rsp_data.scroll_lines) <= MAX_SCROLL;

    `STB_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
    `STB_ASSERT_IMP(a_fill_range, clk, rst_n, rsp_valid, fill_in_range, "fill length beyond store")
    `STB_ASSERT_IMP(a_scroll_range, clk, rst_n, rsp_valid, scroll_in_range, "scroll beyond a full store")
    `STB_ASSERT_IMP(a_hidden_blank, clk, rst_n, rsp_valid && !rsp_data.row_shown, rsp_data.cell_char == '0, "character on a hidden row")

endmodule

bind scrollback_text_buffer stb_checker #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .LINE_CHARS  (LINE_CHARS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_stb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_data (rsp.data)
);
